@@ hdl/nls_pkg.sv @@
// Shared types, character codes and digit helpers for the literal parser.
`timescale 1ns / 1ps

package nls_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_SUFFIX = 3'd3,
    PH_STOP   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    radix_e      radix;
    logic [31:0] term;
    logic [31:0] total;
  } parse_state_t;

  localparam logic [15:0] SECTOR_SCALE_RESET = 16'd512;

  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_UPPER_F = 8'h46;  // 'F'
  localparam logic [7:0] CH_X       = 8'h78;  // 'x'
  localparam logic [7:0] CH_M       = 8'h6d;  // 'm'
  localparam logic [7:0] CH_K       = 8'h6b;  // 'k'
  localparam logic [7:0] CH_S       = 8'h73;  // 's'
  localparam logic [7:0] CH_B       = 8'h62;  // 'b'

  localparam logic [7:0] HEX_LETTER_MIN = 8'd17;  // 'A' - '0'
  localparam logic [7:0] LETTER_GAP     = 8'd7;   // 'A' - '9' - 1
  localparam logic [5:0] NO_DIGIT       = 6'd42;

  localparam int MEGA_SHIFT = 20;
  localparam int KILO_SHIFT = 10;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (c < CH_ZERO || c > CH_UPPER_F) begin
      return NO_DIGIT;
    end
    if (d >= HEX_LETTER_MIN) begin
      d = d - LETTER_GAP;
    end
    return d[5:0];
  endfunction

  function automatic logic [4:0] base_of(input radix_e r);
    logic [4:0] b;
    unique case (r)
      RX_OCT:  b = 5'd8;
      RX_HEX:  b = 5'd16;
      default: b = 5'd10;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/nls_input_stage.sv @@
// Input register holding one character transfer ahead of the parse step.
`timescale 1ns / 1ps

module nls_input_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  nls_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output nls_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  nls_pkg::item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hdl/nls_parse_core.sv @@
// Parser state registers and the one-character update step.
`timescale 1ns / 1ps

module nls_parse_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  nls_pkg::item_t item_i,
  input  logic [15:0]    sector_scale_i,
  output logic [31:0]    result_o
);

  nls_pkg::parse_state_t st_q, st_d, st_n;

  logic              dig_en;
  logic              suf_en;
  logic              dig_ok;
  nls_pkg::radix_e   dig_radix;
  logic [31:0]       dig_term;
  logic [5:0]        dig;
  logic [4:0]        base;
  logic [31:0]       base_mul;
  logic [47:0]       sector_mul;
  logic [31:0]       flush_term;
  logic [7:0]        c;

  assign c          = item_i.character;
  assign sector_mul = 48'(dig_term) * 48'(sector_scale_i);

  always_comb begin
    st_n      = st_q;
    dig_en    = 1'b0;
    suf_en    = 1'b0;
    dig_radix = st_q.radix;
    dig_term  = st_q.term;

    unique case (st_q.phase)
      nls_pkg::PH_START: begin
        if (c == nls_pkg::CH_ZERO) begin
          st_n.phase = nls_pkg::PH_ZERO;
        end else begin
          dig_en    = 1'b1;
          dig_radix = nls_pkg::RX_DEC;
          dig_term  = '0;
        end
      end
      nls_pkg::PH_ZERO: begin
        if (c == nls_pkg::CH_X) begin
          st_n.phase = nls_pkg::PH_DIGITS;
          st_n.radix = nls_pkg::RX_HEX;
          st_n.term  = '0;
        end else begin
          dig_en    = 1'b1;
          dig_radix = nls_pkg::RX_OCT;
          dig_term  = '0;
        end
      end
      nls_pkg::PH_DIGITS: dig_en = 1'b1;
      nls_pkg::PH_SUFFIX: suf_en = 1'b1;
      default: ;
    endcase

    dig  = nls_pkg::digit_of(c);
    base = nls_pkg::base_of(dig_radix);
    dig_ok = ({1'b0, base} > dig);

    unique case (dig_radix)
      nls_pkg::RX_OCT: base_mul = dig_term << 3;
      nls_pkg::RX_HEX: base_mul = dig_term << 4;
      default:         base_mul = (dig_term << 3) + (dig_term << 1);
    endcase

    if (dig_en && dig_ok) begin
      st_n.phase = nls_pkg::PH_DIGITS;
      st_n.radix = dig_radix;
      st_n.term  = base_mul + 32'(dig);
    end else if (suf_en || dig_en) begin
      // digit run ended (or already in suffixes): scale or close the term
      st_n.phase = nls_pkg::PH_SUFFIX;
      st_n.radix = dig_radix;
      st_n.term  = dig_term;
      priority if (c == nls_pkg::CH_M) begin
        st_n.term = dig_term << nls_pkg::MEGA_SHIFT;
      end else if (c == nls_pkg::CH_K) begin
        st_n.term = dig_term << nls_pkg::KILO_SHIFT;
      end else if (c == nls_pkg::CH_S) begin
        st_n.term = sector_mul[31:0];
      end else if (c == nls_pkg::CH_B) begin
        st_n.term = dig_term;
      end else begin
        st_n.total = st_q.total + dig_term;
        st_n.term  = '0;
        if (c >= nls_pkg::CH_ZERO && c <= nls_pkg::CH_NINE) begin
          // decimal digit opens the next term
          if (c == nls_pkg::CH_ZERO) begin
            st_n.phase = nls_pkg::PH_ZERO;
          end else begin
            st_n.phase = nls_pkg::PH_DIGITS;
            st_n.radix = nls_pkg::RX_DEC;
            st_n.term  = 32'(dig);
          end
        end else begin
          st_n.phase = nls_pkg::PH_STOP;
        end
      end
    end
  end

  // end of string closes a term still open in digits or suffixes
  always_comb begin
    if (st_n.phase == nls_pkg::PH_DIGITS || st_n.phase == nls_pkg::PH_SUFFIX) begin
      flush_term = st_n.term;
    end else begin
      flush_term = '0;
    end
  end

  assign result_o = st_n.total + flush_term;

  always_comb begin
    st_d = st_n;
    if (item_i.last) begin
      st_d.phase = nls_pkg::PH_START;
      st_d.radix = nls_pkg::RX_DEC;
      st_d.term  = '0;
      st_d.total = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase <= nls_pkg::PH_START;
      st_q.radix <= nls_pkg::RX_DEC;
      st_q.term  <= '0;
      st_q.total <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last |=> st_q.phase == nls_pkg::PH_START && st_q.term == '0
                              && st_q.total == '0)
    else $error("parse state not cleared after final character");

  a_idle_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == nls_pkg::PH_START || st_q.phase == nls_pkg::PH_ZERO
     || st_q.phase == nls_pkg::PH_STOP) |-> st_q.term == '0)
    else $error("term value nonzero outside digits or suffixes");
`endif

endmodule

@@ hdl/nls_result_stage.sv @@
// Output register for the parsed total, with its valid flag.
`timescale 1ns / 1ps

module nls_result_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] total_i,
  input  logic        out_stall_i,
  output logic        free_o,
  output logic        out_valid_o,
  output logic [31:0] total_o
);

  logic        valid_q, valid_d;
  logic [31:0] total_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      total_q <= total_i;
    end
  end

  assign out_valid_o = valid_q;
  assign total_o     = total_q;

endmodule

@@ hdl/number_literal_suffix_parser.sv @@
// Top level: streaming parser of sized integer literals, one character per transfer.
`timescale 1ns / 1ps

// Parses integer literal text such as "0x1Fk" or "2m512" one character per
// cycle: a steady stream is taken at one character every clock, with no
// gaps between strings. Each character passes through an input register,
// then a combinational parse step (base detection, digit accumulation,
// m/k/s/b scaling, term summing) updates the parser state; the 32x16
// sector multiply and the following add in that step set the clock. A
// string's total (modulo 2^32) is one transfer on total_o, for the
// character marked last only: it is loaded into the result register as
// that character leaves the input register. All other characters give
// no output. The input stalls only while a final character waits behind
// an unread result. sector_scale (reset 512) is written through the cfg
// port, always ready; write it only while idle.
module number_literal_suffix_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        last_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] total_o,
  // sector_scale register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_sector_scale_i
);

  logic [15:0]    sector_scale_q;
  nls_pkg::item_t in_item;
  nls_pkg::item_t stage_item;
  logic           stage_valid;
  logic           out_free;
  logic           step;
  logic           accept;
  logic [31:0]    result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_scale_q <= nls_pkg::SECTOR_SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sector_scale_q <= cfg_sector_scale_i;
    end
  end

  assign in_item.character = character_i;
  assign in_item.last      = last_i;

  // a held character moves on unless it ends a string and the result is blocked
  assign step       = stage_valid && (!stage_item.last || out_free);
  assign in_stall_o = stage_valid && !step;
  assign accept     = in_valid_i && !in_stall_o;

  nls_input_stage u_input (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .item_i    (in_item),
    .advance_i (step),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  nls_parse_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (stage_item),
    .sector_scale_i (sector_scale_q),
    .result_o       (result)
  );

  nls_result_stage u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && stage_item.last),
    .total_i     (result),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .total_o     (total_o)
  );

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stage_valid && stage_item.last && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked final character");
`endif

endmodule
